// ===== hw/rtl/horizontal_box_blur_rgb_macros.svh =====
// Assertion macros for the horizontal box blur block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HORIZONTAL_BOX_BLUR_RGB_MACROS_SVH
`define HORIZONTAL_BOX_BLUR_RGB_MACROS_SVH

`ifndef SYNTH
// Property checked every clock, disabled in reset
`define HBB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define HBB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBB_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define HBB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/hbb_pkg.sv =====
// Shared types and defaults for the horizontal box blur block.
// No dependencies; used by hbb_div and horizontal_box_blur_rgb.
`timescale 1ns / 1ps

package hbb_pkg;

  localparam int CHAN_W = 8;
  localparam int NUM_CH = 3;
  localparam int ROW_W  = 12;

  // Defaults for the top-level parameters
  localparam int HALF_WIDTH_DEF = 8;
  localparam int MAX_ROW_DEF    = 4095;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 12'd640;

  typedef logic [CHAN_W-1:0] chan_t;
  // Channel 0 blue, 1 green, 2 red
  typedef chan_t [NUM_CH-1:0] pixel_t;

endpackage

// ===== hw/rtl/hbb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hbb_div.sv =====
// Division of a window sum by the constant window length, by reciprocal multiply.
// Depends on hbb_pkg for the channel width.
`timescale 1ns / 1ps

module hbb_div #(
  parameter int DIVISOR = 17,
  parameter int IN_W    = 13
) (
  input  logic [IN_W-1:0]     dividend,
  output hbb_pkg::chan_t      quotient
);

  // Shift and rounded-up reciprocal: exact floor for every dividend below 2**IN_W
  localparam int          SH     = IN_W + $clog2(DIVISOR);
  localparam logic [63:0] MULT64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int          PROD_W = 2 * IN_W + 1;

  logic [IN_W:0]       mult;
  logic [PROD_W-1:0]   product;

  assign mult     = MULT64[IN_W:0];
  assign product  = PROD_W'(dividend) * PROD_W'(mult);
  assign quotient = product[SH +: hbb_pkg::CHAN_W];

endmodule

// ===== hw/rtl/horizontal_box_blur_rgb.sv =====
// Horizontal box blur over a raster stream of 8-bit RGB pixels. Each channel of pixel x
// becomes floor(sum of pixels x-N..x+N / (2N+1)), N = HALF_WIDTH; the first and last N
// pixels of a row, and every pixel of a row narrower than 2N+1, pass through. Results lag
// by N pixels and the last pixel of a row flushes the pending ones (tlast on the row's
// last pixel, tuser on the last result an input word causes). The window lives in a
// 2N+1 entry RAM with one write and one registered read port. A word that causes no result
// frees the input after the accept and read-modify-write steps; one that causes results
// also takes a RAM read and an output step for each and waits while the output stalls.
// The window RAM needs no clearing pass after reset: a fill count keeps never-written
// entries out of the sums. Row width 0 or above MAX_ROW is taken as MAX_ROW; the user must
// write configuration only while the block is idle, which the block does not enforce.
// Depends on hbb_pkg, hbb_ram, hbb_div and horizontal_box_blur_rgb_macros.svh.
`timescale 1ns / 1ps
`include "horizontal_box_blur_rgb_macros.svh"

module horizontal_box_blur_rgb #(
  parameter int HALF_WIDTH = hbb_pkg::HALF_WIDTH_DEF,
  parameter int MAX_ROW    = hbb_pkg::MAX_ROW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Pixel input
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,   // blue_in, green_in, red_in
  // Pixel output
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,   // blue_out, green_out, red_out
  output logic                      m_tlast,   // end_of_row
  output logic                      m_tuser,   // last_of_burst
  // Row width register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hbb_pkg::ROW_W-1:0] cfg_data   // row_width
);

  localparam int WIN    = 2 * HALF_WIDTH + 1;
  localparam int AW     = $clog2(WIN);
  localparam int SUM_W  = $clog2(WIN * 255 + 1);
  localparam int FILL_W = $clog2(WIN + 1);
  localparam int CW     = $clog2(MAX_ROW + 1);
  localparam int IDX_W  = $clog2(HALF_WIDTH + 1);
  localparam int NCH    = hbb_pkg::NUM_CH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_RD,
    ST_OUT
  } state_t;

  state_t                      state;
  logic [hbb_pkg::ROW_W-1:0]   row_width;
  hbb_pkg::pixel_t             pix;
  logic [CW-1:0]               col;
  logic                        is_last;
  logic                        avg_ok;
  logic [AW-1:0]               wr_ptr;
  logic [AW-1:0]               rd_addr;
  logic [FILL_W-1:0]           fill;
  logic [IDX_W-1:0]            idx;
  logic [NCH-1:0][SUM_W-1:0]   sums;
  logic [NCH-1:0][SUM_W-1:0]   sums_next;
  hbb_pkg::pixel_t             quot;

  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  hbb_pkg::pixel_t             ram_rdata;

  logic [CW-1:0]               eff_width;
  logic                        last_next;
  logic                        filled;
  logic                        has_out;
  logic [IDX_W-1:0]            idx_start;
  logic [AW:0]                 addr_tmp;
  logic [AW-1:0]               addr_start;
  logic [AW-1:0]               addr_inc;
  logic                        out_free;
  logic                        out_load;
  logic                        burst_end;
  hbb_pkg::pixel_t             out_pix;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Window RAM: written at the update step, read for the oldest entry and for pass-through
  assign ram_we    = (state == ST_UPD);
  assign ram_raddr = (state == ST_IDLE) ? wr_ptr : rd_addr;

  hbb_ram #(
    .WIDTH ($bits(hbb_pkg::pixel_t)),
    .DEPTH (WIN)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (pix),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One constant divider per channel
  for (genvar ch = 0; ch < NCH; ch++) begin : g_div
    hbb_div #(
      .DIVISOR (WIN),
      .IN_W    (SUM_W)
    ) u_div (
      .dividend (sums[ch]),
      .quotient (quot[ch])
    );
  end

  // Effective row width and row-end detect for the incoming word
  always_comb begin
    if (row_width == '0 || 32'(row_width) > 32'(MAX_ROW)) begin
      eff_width = CW'(MAX_ROW);
    end else begin
      eff_width = CW'(row_width);
    end
    last_next = ({1'b0, col} + (CW+1)'(1)) >= {1'b0, eff_width};
  end

  // Running sums: add the new pixel, drop the one leaving the window once it is filled
  assign filled = (fill == FILL_W'(WIN));
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sums_next[ch] = SUM_W'((SUM_W+1)'(sums[ch]) + (SUM_W+1)'(pix[ch])
                    - (filled ? (SUM_W+1)'(ram_rdata[ch]) : '0));
    end
  end

  // Burst setup: first result distance from the newest pixel and its RAM slot
  always_comb begin
    has_out = is_last || (col >= CW'(HALF_WIDTH));
    if (!is_last || col >= CW'(HALF_WIDTH)) begin
      idx_start = IDX_W'(HALF_WIDTH);
    end else begin
      idx_start = col[IDX_W-1:0];
    end
    addr_tmp = {1'b0, wr_ptr} + (AW+1)'(WIN) - (AW+1)'(idx_start);
    if (addr_tmp >= (AW+1)'(WIN)) begin
      addr_tmp = addr_tmp - (AW+1)'(WIN);
    end
    addr_start = addr_tmp[AW-1:0];
    addr_inc   = (rd_addr == AW'(WIN - 1)) ? '0 : rd_addr + AW'(1);
  end

  // Result selection
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == ST_OUT) && out_free;
  assign burst_end = !is_last || (idx == '0);
  assign out_pix   = (avg_ok && idx == IDX_W'(HALF_WIDTH)) ? quot : ram_rdata;

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_width <= hbb_pkg::ROW_WIDTH_RST;
      col       <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      sums      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width <= cfg_data;
      end
      // Output valid: set on a load, dropped once the word is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pix     <= s_tdata;
            is_last <= last_next;
            state   <= ST_UPD;
          end
        end
        ST_UPD: begin
          sums    <= sums_next;
          fill    <= filled ? fill : fill + FILL_W'(1);
          wr_ptr  <= (wr_ptr == AW'(WIN - 1)) ? '0 : wr_ptr + AW'(1);
          col     <= is_last ? '0 : col + CW'(1);
          avg_ok  <= col >= CW'(2 * HALF_WIDTH);
          idx     <= idx_start;
          rd_addr <= addr_start;
          state   <= has_out ? ST_RD : ST_IDLE;
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata  <= out_pix;
            m_tlast  <= is_last && (idx == '0);
            m_tuser  <= burst_end;
            if (burst_end) begin
              state <= ST_IDLE;
            end else begin
              idx     <= idx - IDX_W'(1);
              rd_addr <= addr_inc;
              state   <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `HBB_ASSERT(a_row_end_closes_burst, clk, rst, !(m_tvalid && m_tlast) || m_tuser, "row end not last of burst")
  `HBB_ASSERT(a_sum_bounded_by_fill, clk, rst, 32'(sums[0]) <= 32'(fill) * 32'd255, "blue sum exceeds window fill")
  `HBB_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "input taken during update")

endmodule

// ===== tb/horizontal_box_blur_rgb_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for horizontal_box_blur_rgb: streams rows of RGB pixels, predicts
// every output word with a window model of its own and checks them in order.
// Depends on hbb_pkg and the horizontal_box_blur_rgb RTL.

module horizontal_box_blur_rgb_test;

  localparam int HALF          = hbb_pkg::HALF_WIDTH_DEF;
  localparam int TAPS          = 2 * HALF + 1;
  localparam int ROW_LIMIT     = hbb_pkg::MAX_ROW_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int CALM_AFTER    = 390;  // no idling on either side past this pixel count
  localparam int PIXEL_TARGET  = 460;

  typedef enum int {STYLE_RANDOM, STYLE_EXTREME, STYLE_WHITE, STYLE_DARK} pixel_style_t;

  // One output word: pixel plus row end and burst end flags
  typedef struct packed {
    hbb_pkg::pixel_t px;
    logic            eor;
    logic            lob;
  } blur_word_t;

  // Window model of the blur and queue of the words it still owes
  class blur_scoreboard;
    hbb_pkg::pixel_t window [TAPS];  // newest first
    int unsigned     col;
    int unsigned     row_width;
    blur_word_t      owed_words [$];
    int unsigned     errors;
    int unsigned     words_checked;

    function new();
      col       = 0;
      row_width = 32'(hbb_pkg::ROW_WIDTH_RST);
    endfunction

    function void set_width(logic [hbb_pkg::ROW_W-1:0] w);
      row_width = 32'(w);
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Shift the pixel in and queue the words this pixel releases
    function void take_pixel(hbb_pkg::pixel_t px);
      int unsigned eff;
      int unsigned first;
      int unsigned lastp;
      int unsigned acc;
      bit          ends;
      blur_word_t  w;
      for (int i = TAPS - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = px;
      eff  = (row_width == 0 || row_width > ROW_LIMIT) ? ROW_LIMIT : row_width;
      ends = (col + 1 >= eff);
      if (ends || col >= HALF) begin
        first = (col >= HALF) ? col - HALF : 0;
        lastp = ends ? col : first;
        for (int unsigned p = first; p <= lastp; p++) begin
          if (col >= 2 * HALF && p == col - HALF) begin
            // centered pixel with a full window: floor of the mean
            for (int ch = 0; ch < hbb_pkg::NUM_CH; ch++) begin
              acc = 0;
              for (int i = 0; i < TAPS; i++) acc += window[i][ch];
              w.px[ch] = hbb_pkg::CHAN_W'(acc / TAPS);
            end
          end else begin
            w.px = window[col - p];
          end
          w.eor = ends && (p == col);
          w.lob = (p == lastp);
          owed_words.push_back(w);
        end
      end
      col = ends ? 0 : col + 1;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_word(hbb_pkg::pixel_t px, logic eor, logic lob);
      blur_word_t w;
      if (owed_words.size() == 0) begin
        $error("output word with none owed: blue %0d green %0d red %0d last %0b user %0b",
               px[0], px[1], px[2], eor, lob);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      words_checked++;
      compare("blue_out", 32'(w.px[0]), 32'(px[0]));
      compare("green_out", 32'(w.px[1]), 32'(px[1]));
      compare("red_out", 32'(w.px[2]), 32'(px[2]));
      compare("end_of_row", 32'(w.eor), 32'(eor));
      compare("last_of_burst", 32'(w.lob), 32'(lob));
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [23:0]               s_tdata;   // blue_in, green_in, red_in
  logic                      m_tvalid;
  logic                      m_tready;
  logic [23:0]               m_tdata;   // blue_out, green_out, red_out
  logic                      m_tlast;   // end_of_row
  logic                      m_tuser;   // last_of_burst
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [hbb_pkg::ROW_W-1:0] cfg_data;  // row_width

  blur_scoreboard sb;
  bit             idle_on;
  bit             sink_hold_req;
  int unsigned    pixels_sent;
  int unsigned    rows_done;
  int unsigned    width_writes;

  horizontal_box_blur_rgb uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.match_word(m_tdata, m_tlast, m_tuser);
  end

  // Output side: random stalls, one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one pixel word, wait for it to be taken; returns at the next falling edge
  task automatic send_pixel(input hbb_pkg::pixel_t px);
    if (pixels_sent >= CALM_AFTER) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = px;
    do @(posedge clk); while (!s_tready);
    sb.take_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every owed word is out, then let the block go quiet
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [hbb_pkg::ROW_W-1:0] w);
    cfg_valid = 1'b1;
    cfg_data  = w;
    do @(posedge clk); while (!cfg_ready);
    sb.set_width(w);
    width_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic hbb_pkg::pixel_t make_pixel(pixel_style_t style);
    hbb_pkg::pixel_t px;
    for (int ch = 0; ch < hbb_pkg::NUM_CH; ch++) begin
      case (style)
        STYLE_EXTREME: px[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        STYLE_WHITE:   px[ch] = hbb_pkg::CHAN_W'(8'hFF - $urandom_range(0, 2));
        STYLE_DARK:    px[ch] = hbb_pkg::CHAN_W'($urandom_range(0, 3));
        default:       px[ch] = hbb_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  // Stimulus
  initial begin
    int unsigned               pick;
    int unsigned               k;
    logic [hbb_pkg::ROW_W-1:0] width;
    pixel_style_t              style;
    bit                        hold_done;

    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    idle_on       = 1'b0;
    sink_hold_req = 1'b0;
    hold_done     = 1'b0;
    pixels_sent   = 0;
    rows_done     = 0;
    width_writes  = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Reset width 640, then a lowered width ends the row at column 3
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0FAA55);
    settle();
    write_width(12'd2);
    send_pixel(24'h800FF0);

    // One-pixel rows
    settle();
    write_width(12'd1);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);

    // Widest row, cut short
    settle();
    write_width(12'd4095);
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    settle();
    write_width(12'd1);
    send_pixel(24'h7F807F);

    // Width zero reads as the maximum; lowering it then flushes nine words
    settle();
    write_width(12'd0);
    for (k = 0; k < 9; k++) send_pixel(24'($urandom));
    settle();
    write_width(12'd4);
    send_pixel(24'hFF0001);
    settle();

    // Random rows
    while (pixels_sent < PIXEL_TARGET) begin
      if (pixels_sent >= CALM_AFTER) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      pick  = $urandom_range(0, 9);
      style = pick < 6 ? STYLE_RANDOM : pick < 8 ? STYLE_EXTREME :
              pick == 8 ? STYLE_WHITE : STYLE_DARK;
      pick  = $urandom_range(0, 9);
      if (pick == 9) begin
        // very wide row cut short by lowering the width mid-row
        k     = $urandom_range(0, 2);
        width = (k == 0) ? 12'd0 : (k == 1) ? 12'd4095 :
                hbb_pkg::ROW_W'($urandom_range(100, 4094));
        settle();
        write_width(width);
        repeat ($urandom_range(1, 30)) send_pixel(make_pixel(style));
        settle();
        write_width(hbb_pkg::ROW_W'($urandom_range(1, 24)));
      end else if (rows_done == 0 || $urandom_range(0, 1) == 0) begin
        width = pick < 3 ? hbb_pkg::ROW_W'($urandom_range(1, 16)) :
                pick < 5 ? hbb_pkg::ROW_W'(TAPS) :
                pick < 8 ? hbb_pkg::ROW_W'($urandom_range(18, 48)) :
                hbb_pkg::ROW_W'($urandom_range(49, 120));
        settle();
        write_width(width);
      end
      // once: output holds off while input keeps coming, so the block backs up
      if (!hold_done && pixels_sent > 150) begin
        hold_done     = 1'b1;
        sink_hold_req = 1'b1;
      end
      do send_pixel(make_pixel(style)); while (sb.col != 0 && pixels_sent < PIXEL_TARGET);
      rows_done++;
    end

    settle();
    $display("Sent %0d pixels in %0d random rows plus directed rows, %0d row width writes",
             pixels_sent, rows_done, width_writes);
    $display("Checked %0d output words, %0d field mismatches", sb.words_checked, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d words still owed", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== horizontal_box_blur_rgb.f =====
+incdir+hw/rtl
hw/rtl/hbb_pkg.sv
hw/rtl/hbb_ram.sv
hw/rtl/hbb_div.sv
hw/rtl/horizontal_box_blur_rgb.sv
tb/horizontal_box_blur_rgb_test.sv
